// ===== src/crtm_pkg.sv =====
`default_nettype none
package crtm_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_STARTUP = 2'd2;

  // One stored schedule entry; a field of all ones is the wildcard.
  typedef struct packed {
    logic       startup;
    logic [6:0] minute;
    logic [5:0] hour;
    logic [5:0] day_of_month;
    logic [4:0] month;
    logic [3:0] weekday;
  } entry_t;

  // What the matcher compares the head entry against during a scan.
  typedef struct packed {
    logic       startup_scan;
    logic [6:0] minute;
    logic [5:0] hour;
    logic [5:0] day_of_month;
    logic [4:0] month;
    logic [3:0] weekday;
  } query_t;

endpackage
`default_nettype wire

// ===== src/cron_time_match_scheduler.sv =====
`default_nettype none
// Channel   Ports                                              Handshake
// in        in_req_type .. in_minute_stamp                     in_valid / in_ready
// out       out_fired, out_fired_index, out_last               out_valid / out_ready
// cfg       cfg_wr_data (active_entries)                       cfg_wr_en, no wait
//
// A tick or startup request is accepted, then rotates the whole entry ring once past the
// single comparator at its head, and then closes the request.
// Writes, repeated stamps and unknown requests skip the rotation and only close the request.
// Reset clears the control state, the entry count and the stamp; table entries are
// undefined until written.
// A full output register stalls the rotation whenever a held hit must be pushed out for a new one.
module cron_time_match_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [5:0]  in_entry_index,
  input  wire logic        in_entry_startup,
  input  wire logic [6:0]  in_minute,
  input  wire logic [5:0]  in_hour,
  input  wire logic [5:0]  in_day_of_month,
  input  wire logic [4:0]  in_month,
  input  wire logic [3:0]  in_weekday,
  input  wire logic [31:0] in_minute_stamp,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_fired,
  output logic [5:0]       out_fired_index,
  output logic             out_last,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  crtm_pkg::idx_t   cnt_r, cnt_nxt;
  crtm_pkg::query_t query_r, query_nxt;
  logic [6:0]       active_r, active_nxt;
  logic [31:0]      stamp_r, stamp_nxt;
  logic             seen_r, seen_nxt;
  logic             pend_r, pend_nxt;
  crtm_pkg::idx_t   pend_idx_r, pend_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_fired_r, out_fired_nxt;
  crtm_pkg::idx_t   out_idx_r, out_idx_nxt;
  logic             out_last_r, out_last_nxt;

  crtm_pkg::entry_t cell_q [crtm_pkg::MAX_ENTRIES];
  crtm_pkg::entry_t wr_entry;
  crtm_pkg::cnt_t   scan_lim;
  logic             in_acc, out_free, head_hit, match_hit, rotate;

  assign wr_entry = '{startup: in_entry_startup, minute: in_minute, hour: in_hour,
                      day_of_month: in_day_of_month, month: in_month,
                      weekday: in_weekday};

  // Cell i takes its neighbour's entry on each scan step, so the head cell shows entry
  // number cnt_r; a full scan of the ring restores the original order.
  for (genvar i = 0; i < crtm_pkg::MAX_ENTRIES; i++) begin : g_cell
    crtm_cell u_cell (
      .clk       (clk),
      .load      (in_acc && (in_req_type == crtm_pkg::REQ_WRITE) &&
                  (in_entry_index == 6'(i))),
      .load_data (wr_entry),
      .shift     (rotate),
      .shift_in  (cell_q[(i + 1) % crtm_pkg::MAX_ENTRIES]),
      .q         (cell_q[i])
    );
  end

  crtm_match u_match (
    .entry (cell_q[0]),
    .query (query_r),
    .hit   (match_hit)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign scan_lim = (active_r > 7'(crtm_pkg::MAX_ENTRIES)) ?
                    crtm_pkg::cnt_t'(crtm_pkg::MAX_ENTRIES) : crtm_pkg::cnt_t'(active_r);
  assign head_hit = match_hit && (crtm_pkg::cnt_t'(cnt_r) < scan_lim);
  // A hit with one already held has to push the held one out first.
  assign rotate   = (state_r == ST_SCAN) && (!(head_hit && pend_r) || out_free);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    query_nxt     = query_r;
    active_nxt    = cfg_wr_en ? cfg_wr_data : active_r;
    stamp_nxt     = stamp_r;
    seen_nxt      = seen_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_fired_nxt = out_fired_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pend_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
          query_nxt = '{startup_scan: (in_req_type == crtm_pkg::REQ_STARTUP),
                        minute: in_minute, hour: in_hour,
                        day_of_month: in_day_of_month, month: in_month,
                        weekday: in_weekday};
          if (in_req_type == crtm_pkg::REQ_STARTUP) begin
            state_nxt = ST_SCAN;
          end else if (in_req_type == crtm_pkg::REQ_TICK) begin
            if (!seen_r || (in_minute_stamp != stamp_r)) begin
              stamp_nxt = in_minute_stamp;
              seen_nxt  = 1'b1;
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rotate) begin
          if (head_hit) begin
            if (pend_r) begin
              out_valid_nxt = 1'b1;
              out_fired_nxt = 1'b1;
              out_idx_nxt   = pend_idx_r;
              out_last_nxt  = 1'b0;
            end
            pend_nxt     = 1'b1;
            pend_idx_nxt = cnt_r;
          end
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == crtm_pkg::idx_t'(crtm_pkg::MAX_ENTRIES - 1)) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_fired_nxt = pend_r;
          out_idx_nxt   = pend_r ? pend_idx_r : '0;
          out_last_nxt  = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      active_r    <= '0;
      stamp_r     <= '0;
      seen_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      active_r    <= active_nxt;
      stamp_r     <= stamp_nxt;
      seen_r      <= seen_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    query_r     <= query_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_fired_r <= out_fired_nxt;
    out_idx_r   <= out_idx_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_fired       = out_fired_r;
  assign out_fired_index = 6'(out_idx_r);
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

// ===== src/crtm_cell.sv =====
`default_nettype none
module crtm_cell (
  input  wire logic            clk,
  input  wire logic            load,
  input  wire crtm_pkg::entry_t load_data,
  input  wire logic            shift,
  input  wire crtm_pkg::entry_t shift_in,
  output crtm_pkg::entry_t     q
);

  crtm_pkg::entry_t entry_r;
  crtm_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (load) begin
      entry_nxt = load_data;
    end else if (shift) begin
      entry_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

endmodule
`default_nettype wire

// ===== src/crtm_match.sv =====
`default_nettype none
module crtm_match (
  input  wire crtm_pkg::entry_t entry,
  input  wire crtm_pkg::query_t query,
  output logic                  hit
);

  logic mi_ok, hr_ok, dm_ok, mo_ok, wd_ok;

  always_comb begin
    mi_ok = (&entry.minute)       || (entry.minute == query.minute);
    hr_ok = (&entry.hour)         || (entry.hour == query.hour);
    dm_ok = (&entry.day_of_month) || (entry.day_of_month == query.day_of_month);
    mo_ok = (&entry.month)        || (entry.month == query.month);
    wd_ok = (&entry.weekday)      || (entry.weekday == query.weekday);
    if (query.startup_scan) begin
      hit = entry.startup;
    end else begin
      hit = !entry.startup && mi_ok && hr_ok && dm_ok && mo_ok && wd_ok;
    end
  end

endmodule
`default_nettype wire
